/* rtl/ectc_pkg.sv */
// Shared word types for the epoch seconds to calendar pipeline.
package ectc_pkg;

   // Whole days and the second of the day, after the first split.
   typedef struct packed {
      logic [15:0] days;
      logic [16:0] rem;
   } ectc_day_type;

   // Clock fields, weekday, year and day of year, before the month walk.
   typedef struct packed {
      logic [5:0] sec;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [2:0] weekday;
      logic [7:0] year;
      logic [8:0] yday;
      logic       leap;
   } ectc_field_type;

   // Finished result word.
   typedef struct packed {
      logic [5:0] sec;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] mday;
      logic [3:0] month;
      logic [7:0] year;
      logic [2:0] weekday;
      logic [8:0] yday;
   } ectc_result_type;

endpackage

/* rtl/ectc_day_split.sv */
// Two-stage split of the second count into whole days and second of the day.
module ectc_day_split (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  logic [31:0]          in_seconds,
   output logic                 out_valid,
   input  logic                 out_stall,
   output ectc_pkg::ectc_day_type out_day
);
   import ectc_pkg::*;

   // 86400 = 128 * 675: drop seven bits, then divide by 675 by reciprocal.
   localparam int          DAY_SHIFT = 35;
   localparam logic [9:0]  DAY_DIV   = 10'd675;
   localparam logic [25:0] DAY_RECIP =
      26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);

   logic         v1_ff, v2_ff;
   logic         adv1, adv2;
   logic [24:0]  x1_ff;
   logic [6:0]   lo1_ff;
   logic [15:0]  q1_ff;
   logic [15:0]  q1_in;
   logic [50:0]  prod1;
   logic [25:0]  qscaled;
   logic [9:0]   rem_hi;
   ectc_day_type day_ff, day_in;

   assign adv2     = !v2_ff || !out_stall;
   assign adv1     = !v1_ff || adv2;
   assign in_stall = !adv1;

   always_comb begin
      prod1 = 51'(in_seconds[31:7]) * 51'(DAY_RECIP);
      q1_in = prod1[DAY_SHIFT +: 16];
   end

   always_comb begin
      qscaled     = 26'(q1_ff) * 26'(DAY_DIV);
      rem_hi      = 10'({1'b0, x1_ff} - qscaled);
      day_in.days = q1_ff;
      day_in.rem  = {rem_hi, lo1_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         x1_ff  <= in_seconds[31:7];
         lo1_ff <= in_seconds[6:0];
         q1_ff  <= q1_in;
      end
      if (adv2) begin
         day_ff <= day_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_day   = day_ff;

endmodule

/* rtl/ectc_field_split.sv */
// Three stages that give the clock fields, weekday, year and day of year.
module ectc_field_split (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  ectc_pkg::ectc_day_type in_day,
   output logic                   out_valid,
   input  logic                   out_stall,
   output ectc_pkg::ectc_field_type out_field
);
   import ectc_pkg::*;

   localparam int          MIN_SHIFT   = 23;
   localparam logic [17:0] MIN_RECIP   = 18'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);
   localparam int          HOUR_SHIFT  = 17;
   localparam logic [11:0] HOUR_RECIP  = 12'(((64'd1 << HOUR_SHIFT) + 64'd59) / 64'd60);
   localparam int          WEEK_SHIFT  = 19;
   localparam logic [16:0] WEEK_RECIP  = 17'(((64'd1 << WEEK_SHIFT) + 64'd6) / 64'd7);
   localparam int          QUAD_SHIFT  = 27;
   localparam logic [16:0] QUAD_RECIP  =
      17'(((64'd1 << QUAD_SHIFT) + 64'd1460) / 64'd1461);
   localparam logic [5:0]  SIXTY       = 6'd60;
   localparam logic [2:0]  WEEK_LEN    = 3'd7;
   localparam logic [10:0] QUAD_DAYS   = 11'd1461;
   localparam logic [10:0] YEAR1_START = 11'd366;
   localparam logic [10:0] YEAR2_START = 11'd731;
   localparam logic [10:0] YEAR3_START = 11'd1096;
   localparam logic [7:0]  BASE_YEAR   = 8'd40;

   logic        v3_ff, v4_ff, v5_ff;
   logic        adv3, adv4, adv5;

   // stage 3: quotients by reciprocal
   logic [34:0] mprod;
   logic [32:0] wprod, cprod;
   logic [15:0] wx_in;
   logic [15:0] days3_ff, wx3_ff;
   logic [16:0] rem3_ff;
   logic [10:0] mt3_ff;
   logic [12:0] wq3_ff;
   logic [5:0]  c3_ff;

   // stage 4: remainders and hour
   logic [22:0] hprod;
   logic [5:0]  sec4_in, sec4_ff;
   logic [4:0]  hr4_in, hr4_ff;
   logic [2:0]  wd4_in, wd4_ff;
   logic [10:0] dc4_in, dc4_ff;
   logic [10:0] mt4_ff;
   logic [5:0]  c4_ff;

   // stage 5: minute and year within the four-year cycle
   logic [1:0]  y4;
   logic [10:0] ybase;
   ectc_field_type field_in, field_ff;

   assign adv5     = !v5_ff || !out_stall;
   assign adv4     = !v4_ff || adv5;
   assign adv3     = !v3_ff || adv4;
   assign in_stall = !adv3;

   always_comb begin
      wx_in = in_day.days + 16'd1;
      mprod = 35'(in_day.rem) * 35'(MIN_RECIP);
      wprod = 33'(wx_in) * 33'(WEEK_RECIP);
      cprod = 33'(in_day.days) * 33'(QUAD_RECIP);
   end

   always_comb begin
      sec4_in = 6'(rem3_ff - 17'(mt3_ff) * 17'(SIXTY));
      hprod   = 23'(mt3_ff) * 23'(HOUR_RECIP);
      hr4_in  = hprod[HOUR_SHIFT +: 5];
      wd4_in  = 3'(wx3_ff - 16'(wq3_ff) * 16'(WEEK_LEN));
      dc4_in  = 11'(days3_ff - 16'(c3_ff) * 16'(QUAD_DAYS));
   end

   // The range 1940..2076 holds no skipped century leap, so every fourth
   // year from 1940 is a leap year.
   always_comb begin
      if (dc4_ff >= YEAR3_START) begin
         y4    = 2'd3;
         ybase = YEAR3_START;
      end else if (dc4_ff >= YEAR2_START) begin
         y4    = 2'd2;
         ybase = YEAR2_START;
      end else if (dc4_ff >= YEAR1_START) begin
         y4    = 2'd1;
         ybase = YEAR1_START;
      end else begin
         y4    = 2'd0;
         ybase = 11'd0;
      end
      field_in.sec     = sec4_ff;
      field_in.minute  = 6'(mt4_ff - 11'(hr4_ff) * 11'(SIXTY));
      field_in.hour    = hr4_ff;
      field_in.weekday = wd4_ff;
      field_in.year    = BASE_YEAR + {c4_ff, 2'b00} + {6'd0, y4};
      field_in.yday    = 9'(dc4_ff - ybase);
      field_in.leap    = (y4 == 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv3) v3_ff <= in_valid;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         days3_ff <= in_day.days;
         rem3_ff  <= in_day.rem;
         wx3_ff   <= wx_in;
         mt3_ff   <= mprod[MIN_SHIFT +: 11];
         wq3_ff   <= wprod[WEEK_SHIFT +: 13];
         c3_ff    <= cprod[QUAD_SHIFT +: 6];
      end
      if (adv4) begin
         sec4_ff <= sec4_in;
         hr4_ff  <= hr4_in;
         wd4_ff  <= wd4_in;
         dc4_ff  <= dc4_in;
         mt4_ff  <= mt3_ff;
         c4_ff   <= c3_ff;
      end
      if (adv5) begin
         field_ff <= field_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_field = field_ff;

endmodule

/* rtl/ectc_month_split.sv */
// Two-stage walk of the day of year into month and day of month.
module ectc_month_split (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  ectc_pkg::ectc_field_type in_field,
   output logic                     out_valid,
   input  logic                     out_stall,
   output ectc_pkg::ectc_result_type out_result
);
   import ectc_pkg::*;

   localparam int MONTHS = 12;

   // First day of year of each month; March onward moves by one in a leap year.
   function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
      logic [8:0] base;
      begin
         case (m)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
         endcase
         if (leap && m >= 4'd2) base = base + 9'd1;
         return base;
      end
   endfunction

   logic           v6_ff, v7_ff;
   logic           adv6, adv7;
   logic [3:0]     month6_in, month6_ff;
   ectc_field_type field6_ff;
   ectc_result_type result_in, result_ff;

   assign adv7     = !v7_ff || !out_stall;
   assign adv6     = !v6_ff || adv7;
   assign in_stall = !adv6;

   // Count the month starts already passed.
   always_comb begin
      month6_in = 4'd0;
      for (int m = 1; m < MONTHS; m++) begin
         month6_in = month6_in + {3'd0, (in_field.yday >= month_start(4'(m), in_field.leap))};
      end
   end

   always_comb begin
      result_in.sec     = field6_ff.sec;
      result_in.minute  = field6_ff.minute;
      result_in.hour    = field6_ff.hour;
      result_in.mday    = 5'(field6_ff.yday - month_start(month6_ff, field6_ff.leap) + 9'd1);
      result_in.month   = month6_ff;
      result_in.year    = field6_ff.year;
      result_in.weekday = field6_ff.weekday;
      result_in.yday    = field6_ff.yday;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (adv6) v6_ff <= in_valid;
         if (adv7) v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv6) begin
         month6_ff <= month6_in;
         field6_ff <= in_field;
      end
      if (adv7) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = v7_ff;
   assign out_result = result_ff;

endmodule

/* rtl/epoch_seconds_to_calendar.sv */
// Top level: seconds after 1940-01-01 00:00:00 to broken-down calendar time.
//
// req_valid/req_stall carry one word: a 32-bit unsigned second count.
// rsp_valid/rsp_stall carry one word per request: second, minute, hour,
// day of month, month 0..11, year minus 1900, weekday (Sunday 0) and
// day of year. Words leave in the order they arrived.
// From acceptance to rsp_valid, two stages split off whole days,
// three give the clock fields, weekday and year, and two walk the
// months. Throughput is one word per cycle while rsp_stall is low;
// every stage holds a valid bit and its own load enable, so bubbles
// close up under stall. A stage that holds a word and cannot pass it
// on holds it; when the receiver stalls, the pipe fills and req_stall
// rises once the first stage is occupied. Reset clears the valid bits;
// no words are lost or created after reset. Data registers are not reset.
module epoch_seconds_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_second_of_minute,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [4:0]  rsp_hour_of_day,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month_index,
   output logic [7:0]  rsp_years_after_1900,
   output logic [2:0]  rsp_weekday,
   output logic [8:0]  rsp_day_of_year
);
   import ectc_pkg::*;

   logic            day_valid, day_stall;
   logic            field_valid, field_stall;
   ectc_day_type    day;
   ectc_field_type  field;
   ectc_result_type result;

   ectc_day_split u_day_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_seconds (req_epoch_seconds),
      .out_valid  (day_valid),
      .out_stall  (day_stall),
      .out_day    (day)
   );

   ectc_field_split u_field_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (day_valid),
      .in_stall  (day_stall),
      .in_day    (day),
      .out_valid (field_valid),
      .out_stall (field_stall),
      .out_field (field)
   );

   ectc_month_split u_month_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (field_valid),
      .in_stall   (field_stall),
      .in_field   (field),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (result)
   );

   assign rsp_second_of_minute = result.sec;
   assign rsp_minute_of_hour   = result.minute;
   assign rsp_hour_of_day      = result.hour;
   assign rsp_day_of_month     = result.mday;
   assign rsp_month_index      = result.month;
   assign rsp_years_after_1900 = result.year;
   assign rsp_weekday          = result.weekday;
   assign rsp_day_of_year      = result.yday;

endmodule
